[sv/spfla_pkg.sv]
`default_nettype none
package spfla_pkg;

	localparam int unsigned POOL_SLOTS = 256;
	localparam int unsigned SLOT_W = $clog2(POOL_SLOTS);
	localparam int unsigned CNT_W = SLOT_W + 1;

	localparam logic [CNT_W-1:0] NO_LINK = '1;
	localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(POOL_SLOTS);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	localparam logic [1:0] MODE_GET   = 2'd0;
	localparam logic [1:0] MODE_PUT   = 2'd1;
	localparam logic [1:0] MODE_RESET = 2'd2;

	typedef enum logic [1:0] {
		OP_GET,
		OP_PUT,
		OP_RESET,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [SLOT_W-1:0] slot_index;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] granted_slot;
		logic [CNT_W-1:0]  used_count;
		logic [CNT_W-1:0]  free_count;
	} result_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] s;
		s = v;
		if (s == '0) s = CNT_W'(1);
		if (s > CNT_W'(POOL_SLOTS)) s = CNT_W'(POOL_SLOTS);
		return s;
	endfunction

endpackage
`default_nettype wire

[sv/spfla_front.sv]
`default_nettype none
module spfla_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire spfla_pkg::item_t item,
	output logic                 busy,
	output logic                 cmd_valid,
	output spfla_pkg::cmd_t      cmd,
	input  wire logic            cmd_pop
);
	import spfla_pkg::*;

	localparam int unsigned DEPTH = 2;

	cmd_t       fifo_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.slot = item.slot_index;
		unique case (item.mode)
			MODE_GET:   cls.op = OP_GET;
			MODE_PUT:   cls.op = OP_PUT;
			MODE_RESET: cls.op = OP_RESET;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign busy      = (cnt_q == 2'(DEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/spfla_back.sv]
`default_nettype none
module spfla_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	input  wire spfla_pkg::cmd_t              cmd,
	output logic                              cmd_pop,
	input  wire logic                         cfg_valid,
	input  wire logic [spfla_pkg::CNT_W-1:0]  cfg_data,
	output logic                              done,
	output spfla_pkg::result_t                result
);
	import spfla_pkg::*;

	typedef enum logic {
		B_IDLE,
		B_READ
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  link_mem [POOL_SLOTS];
	logic [CNT_W-1:0]  rd_q;
	logic [CNT_W-1:0]  active_q;
	logic [CNT_W-1:0]  pool_q;
	logic [SLOT_W-1:0] head_q;
	logic              head_valid_q;
	logic [CNT_W-1:0]  linked_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  avail_q;
	logic              fwd_q;
	logic [CNT_W-1:0]  fwd_data_q;
	logic              done_q;
	result_t           res_q;

	logic              go;
	logic              lazy;
	logic              grant;
	logic              put_ok;
	logic              we;
	logic [SLOT_W-1:0] waddr;
	logic [CNT_W-1:0]  wdata;
	logic              re;
	logic [CNT_W-1:0]  nx;
	logic [CNT_W-1:0]  pool_new;

	assign go       = (state_q == B_IDLE) && cmd_valid;
	assign cmd_pop  = go;
	assign lazy     = go && (cmd.op == OP_GET) && (linked_q < pool_q);
	assign grant    = go && (cmd.op == OP_GET) && (avail_q != '0) && head_valid_q;
	assign put_ok   = go && (cmd.op == OP_PUT) && (used_q != '0);
	assign re       = grant && (avail_q != CNT_W'(1));
	assign we       = lazy || put_ok;
	assign nx       = fwd_q ? fwd_data_q : rd_q;
	assign pool_new = clamp_size(active_q);

	always_comb begin
		if (lazy) begin
			waddr = linked_q[SLOT_W-1:0];
			wdata = linked_q + CNT_W'(1);
		end else begin
			waddr = cmd.slot;
			wdata = head_valid_q ? {1'b0, head_q} : NO_LINK;
		end
	end

	always_ff @(posedge clk) begin
		if (we) link_mem[waddr] <= wdata;
		if (re) rd_q <= link_mem[head_q];
	end

	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			active_q     <= ACTIVE_RESET;
			pool_q       <= clamp_size(ACTIVE_RESET);
			head_q       <= '0;
			head_valid_q <= 1'b1;
			linked_q     <= '0;
			used_q       <= '0;
			avail_q      <= clamp_size(ACTIVE_RESET);
			fwd_q        <= 1'b0;
			fwd_data_q   <= '0;
			done_q       <= 1'b0;
			res_q        <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) active_q <= cfg_data;
			unique case (state_q)
				B_IDLE: begin
					if (go) begin
						res_q.status       <= ST_OK;
						res_q.granted_slot <= '0;
						res_q.used_count   <= used_q;
						res_q.free_count   <= avail_q;
						done_q             <= 1'b1;
						unique case (cmd.op)
							OP_GET: begin
								if (lazy) linked_q <= linked_q + CNT_W'(1);
								if (grant) begin
									used_q             <= used_q + CNT_W'(1);
									avail_q            <= avail_q - CNT_W'(1);
									res_q.granted_slot <= head_q;
									res_q.used_count   <= used_q + CNT_W'(1);
									res_q.free_count   <= avail_q - CNT_W'(1);
									if (re) begin
										// link read in flight; a same-cycle lazy link wins
										done_q     <= 1'b0;
										state_q    <= B_READ;
										fwd_q      <= lazy && (linked_q[SLOT_W-1:0] == head_q);
										fwd_data_q <= linked_q + CNT_W'(1);
									end else begin
										head_valid_q <= 1'b0;
									end
								end else begin
									res_q.status <= ST_EMPTY;
								end
							end
							OP_PUT: begin
								if (put_ok) begin
									head_q           <= cmd.slot;
									head_valid_q     <= 1'b1;
									used_q           <= used_q - CNT_W'(1);
									avail_q          <= avail_q + CNT_W'(1);
									res_q.used_count <= used_q - CNT_W'(1);
									res_q.free_count <= avail_q + CNT_W'(1);
								end else begin
									res_q.status <= ST_REFUSED;
								end
							end
							OP_RESET: begin
								pool_q           <= pool_new;
								linked_q         <= '0;
								used_q           <= '0;
								avail_q          <= pool_new;
								head_q           <= '0;
								head_valid_q     <= 1'b1;
								res_q.used_count <= '0;
								res_q.free_count <= pool_new;
							end
							default: ;
						endcase
					end
				end
				B_READ: begin
					head_q       <= nx[SLOT_W-1:0];
					head_valid_q <= (nx < CNT_W'(POOL_SLOTS));
					done_q       <= 1'b1;
					state_q      <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/slot_pool_free_list_allocator.sv]
// Items wait in a 2-entry queue that absorbs bursts; the back end then
// registers done, after its link read for a get that follows a link.
// Throughput: one item per cycle for put/reset while the back end is idle;
// a get that follows a link holds it in the registered link memory read.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset (arst_n): pool of 256 slots, empty queue; link memory is not cleared.
`default_nettype none
module slot_pool_free_list_allocator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire spfla_pkg::item_t             item,
	output logic                              busy,
	output logic                              done,
	output spfla_pkg::result_t                result,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [spfla_pkg::CNT_W-1:0]  cfg_data
);
	import spfla_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	assign cfg_ready = 1'b1;

	spfla_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	spfla_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire

[sv/spfla_chk.sv]
`default_nettype none
module spfla_chk (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         busy,
	input  wire logic                         done,
	input  wire spfla_pkg::result_t           result
);
	import spfla_pkg::*;

	logic [CNT_W:0] total;
	assign total = {1'b0, result.used_count} + {1'b0, result.free_count};

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_EMPTY ||
			result.status == ST_REFUSED))
		else $error("undefined status code");

	a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |-> (result.granted_slot == '0))
		else $error("slot granted on failed item");

	a_refused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_REFUSED) |-> (result.used_count == '0))
		else $error("put refused while slots in use");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (total <= (CNT_W+1)'(POOL_SLOTS)))
		else $error("used plus free exceeds pool");

	a_strobe_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy, 2) || $past(start, 2) || $past(start, 3) ||
			$past(done, 2) || $past(busy, 1))
		else $error("result without a prior item");

endmodule

bind slot_pool_free_list_allocator spfla_chk u_spfla_chk (.*);
`default_nettype wire

[tb/tb_slot_pool_free_list_allocator.sv]
`timescale 1ns / 100ps
module tb_slot_pool_free_list_allocator;
	import spfla_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             start;
	item_t            item;
	logic             busy;
	logic             done;
	result_t          result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	slot_pool_free_list_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// pool shadow state
	logic [CNT_W-1:0]  slot_links [POOL_SLOTS];
	bit                link_set [POOL_SLOTS];
	logic [CNT_W-1:0]  head;
	bit                head_ok;
	logic [CNT_W-1:0]  linked;
	logic [CNT_W-1:0]  used;
	logic [CNT_W-1:0]  avail;
	logic [CNT_W-1:0]  pool;
	logic [CNT_W-1:0]  cfg_slots;
	logic [SLOT_W-1:0] held [$];

	result_t     expected_results [$];
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned mismatches;
	int unsigned grants;
	int unsigned empty_gets;
	int unsigned refused_puts;
	int unsigned pool_settings;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[slot_pool_free_list_allocator] ERROR");
		$finish;
	end

	function automatic logic [CNT_W-1:0] pool_from_cfg(input logic [CNT_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > 256 || v > POOL_SLOTS)
			return (POOL_SLOTS < 256) ? CNT_W'(POOL_SLOTS) : CNT_W'(256);
		return v;
	endfunction

	function automatic void pool_restart();
		pool = pool_from_cfg(cfg_slots);
		linked = 0;
		used = 0;
		avail = pool;
		head = 0;
		head_ok = 1'b1;
		held.delete();
	endfunction

	function automatic void pool_apply(input item_t it, output result_t r);
		r = '0;
		r.status = ST_OK;
		case (op_t'(it.mode))
			OP_GET: begin
				if (linked < pool) begin
					slot_links[linked[SLOT_W-1:0]] = linked + 1;
					link_set[linked[SLOT_W-1:0]] = 1'b1;
					linked++;
				end
				if (avail != 0 && head_ok) begin
					r.granted_slot = head[SLOT_W-1:0];
					held.push_back(head[SLOT_W-1:0]);
					grants++;
					used++;
					avail--;
					if (avail != 0) begin
						head = slot_links[head[SLOT_W-1:0]];
						head_ok = (head < 256) && (head < POOL_SLOTS);
					end else begin
						head_ok = 1'b0;
					end
				end else begin
					r.status = ST_EMPTY;
					empty_gets++;
				end
			end
			OP_PUT: begin
				if (used == 0) begin
					r.status = ST_REFUSED;
					refused_puts++;
				end else begin
					slot_links[it.slot_index] = head_ok ? head : NO_LINK;
					link_set[it.slot_index] = 1'b1;
					head = {1'b0, it.slot_index};
					head_ok = 1'b1;
					used--;
					avail++;
				end
			end
			OP_RESET: pool_restart();
			default: ;
		endcase
		r.used_count = used;
		r.free_count = avail;
	endfunction

	// a get that would follow a link never stored
	function automatic bit get_reads_unwritten();
		bit lazy_here;
		if (!(avail > 1 && head_ok))
			return 1'b0;
		lazy_here = (linked < pool) && (head == linked);
		return !(link_set[head[SLOT_W-1:0]] || lazy_here);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	task automatic send_item(input op_t op, input logic [SLOT_W-1:0] slot);
		item_t   it;
		result_t want;
		it.mode = op;
		it.slot_index = slot;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pool_apply(it, want);
		expected_results.push_back(want);
		items_sent++;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_gapped(input op_t op, input logic [SLOT_W-1:0] slot);
		send_item(op, slot);
		pause_sender(pick_gap());
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_pool_size(input logic [CNT_W-1:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_slots = v;
		pool_settings++;
	endtask

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: %p", result);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatches++;
				end
				if (result.granted_slot !== want.granted_slot) begin
					$error("granted_slot: expected %0d, got %0d",
						want.granted_slot, result.granted_slot);
					mismatches++;
				end
				if (result.used_count !== want.used_count) begin
					$error("used_count: expected %0d, got %0d",
						want.used_count, result.used_count);
					mismatches++;
				end
				if (result.free_count !== want.free_count) begin
					$error("free_count: expected %0d, got %0d",
						want.free_count, result.free_count);
					mismatches++;
				end
			end
		end
	end

	task automatic test_default_pool();
		send_gapped(OP_GET, 8'hFF);
		send_gapped(OP_GET, 8'h00);
		send_gapped(OP_NOP, 8'hA5);
		send_gapped(OP_PUT, 8'hFF);
		send_gapped(OP_PUT, 8'h00);
		send_gapped(OP_PUT, 8'h07);
		send_gapped(OP_GET, 8'h5A);
	endtask

	task automatic test_size_extremes();
		write_pool_size(9'd0);
		send_gapped(OP_RESET, 8'h00);
		send_gapped(OP_GET, 8'h00);
		send_gapped(OP_GET, 8'h00);
		send_gapped(OP_PUT, 8'h00);
		send_gapped(OP_GET, 8'h00);
		write_pool_size(9'h1FF);
		send_gapped(OP_RESET, 8'hFF);
		send_gapped(OP_GET, 8'h00);
		write_pool_size(9'd257);
		send_gapped(OP_RESET, 8'h00);
	endtask

	// stale end-of-list link reached while the free count still says one is left
	task automatic test_broken_chain();
		write_pool_size(9'd3);
		send_gapped(OP_RESET, 8'h00);
		repeat (3) send_gapped(OP_GET, 8'h00);
		send_gapped(OP_PUT, 8'd3);
		send_gapped(OP_RESET, 8'h00);
		repeat (2) send_gapped(OP_GET, 8'h00);
		repeat (2) send_gapped(OP_PUT, 8'd2);
		repeat (3) send_gapped(OP_GET, 8'h00);
		send_gapped(OP_PUT, 8'd3);
	endtask

	task automatic test_random_traffic();
		logic [CNT_W-1:0]  sz;
		logic [SLOT_W-1:0] slot;
		op_t               op;
		int unsigned       r;
		int unsigned       idx;
		bit                calm;
		for (int p = 0; p < 12; p++) begin
			case (p)
				0: sz = 1;
				1: sz = 2;
				2: sz = 3;
				3: sz = 4;
				4: sz = 6;
				5: sz = 9;
				6: sz = 16;
				7, 8: sz = CNT_W'($urandom_range(256, 1));
				9: sz = 256;
				10: sz = 0;
				default: sz = CNT_W'($urandom_range(511, 257));
			endcase
			calm = (p == 3) || (p == 8);
			write_pool_size(sz);
			send_item(OP_RESET, SLOT_W'($urandom));
			for (int n = 0; n < 75; n++) begin
				slot = SLOT_W'($urandom);
				r = $urandom_range(99);
				if (r < 45) begin
					op = OP_GET;
				end else if (r < 80 && held.size() != 0) begin
					op = OP_PUT;
					idx = $urandom_range(held.size() - 1);
					slot = held[idx];
					held.delete(idx);
				end else if (r < 90) begin
					op = OP_PUT;
				end else if (r < 95) begin
					op = OP_NOP;
				end else begin
					op = OP_RESET;
				end
				if (op == OP_GET && get_reads_unwritten())
					op = OP_RESET;
				send_item(op, slot);
				if ($urandom_range(199) == 0)
					wait_drained();
				else if (!calm)
					pause_sender(pick_gap());
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		cfg_slots = ACTIVE_RESET;
		foreach (link_set[i])
			link_set[i] = 1'b0;
		pool_restart();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_default_pool();
		test_size_extremes();
		test_broken_chain();
		test_random_traffic();

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d items sent, %0d results checked over %0d pool size settings",
			items_sent, results_checked, pool_settings);
		$display("%0d slots granted, %0d gets on an empty pool, %0d puts refused",
			grants, empty_gets, refused_puts);
		if (mismatches == 0)
			$display("[slot_pool_free_list_allocator] OK");
		else
			$display("[slot_pool_free_list_allocator] ERROR");
		$finish;
	end

endmodule
